FILE: rtl/core/ljpf_pkg.sv
// shared types, constants and register map of the lennard-jones pair force core
`default_nettype none
package ljpf_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_BOX_X    = 3'd0;
  localparam logic [2:0] REG_BOX_Y    = 3'd1;
  localparam logic [2:0] REG_BOX_Z    = 3'd2;
  localparam logic [2:0] REG_CUTOFF   = 3'd3;
  localparam logic [2:0] REG_SIGMA6   = 3'd4;
  localparam logic [2:0] REG_EPSILON  = 3'd5;

  localparam logic [31:0] BOX_RESET    = 32'd121530778;
  localparam logic [31:0] CUTOFF_RESET = 32'd5029108;
  localparam logic [31:0] SIGMA6_RESET = 32'd121301238;
  localparam logic [31:0] EPS_RESET    = 32'd43562187;

  // pair tally saturates at 256
  localparam logic [8:0]  TALLY_CAP    = 9'd256;

  localparam logic [63:0] ONE_Q32      = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HALF_Q32     = 64'h0000_0000_8000_0000;
  localparam logic [46:0] TERM_CAP     = {47{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_MUL_ISSUE,
    ST_MUL_WAIT,
    ST_CHECK,
    ST_DIV_ISSUE,
    ST_DIV_WAIT,
    ST_EMIT
  } state_e;

  // multiply steps in issue order
  typedef enum logic [3:0] {
    OP_SQX, OP_SQY, OP_SQZ,
    OP_S1, OP_S2, OP_S3,
    OP_E1, OP_E2,
    OP_F1, OP_F2, OP_F3,
    OP_FX, OP_FY, OP_FZ
  } op_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_22,
    SH_32
  } shift_e;

  typedef struct packed {
    logic load;
    logic wrap;
    logic mul_start;
    logic commit;
    logic div_start;
    logic irsq_load;
    logic tally_inc;
    logic emit;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic pair_present;
    logic last;
    logic in_range;
    logic mul_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/ljpf_mul.sv
// iterative 64x64 multiplier with shifted, saturated result, one 32x32 product a cycle
`default_nettype none
module ljpf_mul (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [63:0]          a_i,
  input  wire logic [63:0]          b_i,
  input  ljpf_pkg::shift_e          sh_i,
  output logic                      done_o,
  output logic [63:0]               res_o
);
  import ljpf_pkg::*;

  logic [63:0]  a_q, b_q, res_q;
  shift_e       sh_q;
  logic [127:0] prod_q, ppx;
  logic [1:0]   cnt_q;
  logic         busy_q, fin_q, done_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp, sel;
  logic         ovf;

  always_comb begin
    unique case (cnt_q)
      2'd0: begin pa = a_q[31:0];  pb = b_q[31:0];  end
      2'd1: begin pa = a_q[31:0];  pb = b_q[63:32]; end
      2'd2: begin pa = a_q[63:32]; pb = b_q[31:0];  end
      default: begin pa = a_q[63:32]; pb = b_q[63:32]; end
    endcase
    pp = {32'b0, pa} * {32'b0, pb};
    unique case (cnt_q)
      2'd0:    ppx = {64'b0, pp};
      2'd3:    ppx = {pp, 64'b0};
      default: ppx = {32'b0, pp, 32'b0};
    endcase
  end

  always_comb begin
    unique case (sh_q)
      SH_0:    begin ovf = |prod_q[127:64]; sel = prod_q[63:0];  end
      SH_22:   begin ovf = |prod_q[127:86]; sel = prod_q[85:22]; end
      SH_32:   begin ovf = |prod_q[127:96]; sel = prod_q[95:32]; end
      default: begin ovf = 1'b1;            sel = prod_q[63:0];  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= fin_q;
      fin_q  <= busy_q && (cnt_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      sh_q   <= sh_i;
      prod_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_q + ppx;
    end
    if (fin_q) begin
      res_q <= ovf ? {64{1'b1}} : sel;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

FILE: rtl/core/ljpf_div.sv
// restoring divider for the reciprocal of the squared distance, one quotient bit a cycle
`default_nettype none
module ljpf_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [51:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  import ljpf_pkg::*;

  logic [51:0] den_q, rem_q;
  logic [63:0] quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [52:0] r2, diff;
  logic        ge;

  // dividend is all ones, so a one shifts in every step
  assign r2   = {rem_q, 1'b1};
  assign ge   = r2 >= {1'b0, den_q};
  assign diff = r2 - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[51:0] : r2[51:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/ljpf_datapath.sv
// datapath: config registers, wrap, operand select, accumulators and result register
`default_nettype none
module ljpf_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_addr_i,
  input  wire logic [31:0]   cfg_data_i,
  input  wire logic [191:0]  in_data_i,
  input  wire logic          in_present_i,
  input  wire logic          in_last_i,
  input  ljpf_pkg::cmd_t     cmd_i,
  output ljpf_pkg::sts_t     sts_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output logic [47:0]        force_x_o,
  output logic [47:0]        force_y_o,
  output logic [47:0]        force_z_o,
  output logic [47:0]        energy_o,
  output logic [8:0]         pairs_counted_o
);
  import ljpf_pkg::*;

  function automatic logic signed [34:0] wrap_d(input logic signed [34:0] d,
                                                input logic [31:0] len);
    logic signed [35:0] d2, l, de, r;
    d2 = {d, 1'b0};
    l  = {4'b0, len};
    de = {d[34], d};
    if (d2 >= l) begin
      r = de - l;
    end else if (d2 < -l) begin
      r = de + l;
    end else begin
      r = de;
    end
    return r[34:0];
  endfunction

  function automatic logic [33:0] mag_d(input logic signed [34:0] d);
    logic signed [34:0] n;
    n = -d;
    return d[34] ? n[33:0] : d[33:0];
  endfunction

  function automatic logic [31:0] clamp_d(input logic [33:0] m);
    return (m > 34'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
  endfunction

  function automatic logic signed [47:0] term(input logic [46:0] m, input logic neg);
    logic signed [47:0] p;
    p = {1'b0, m};
    return neg ? -p : p;
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
                                                 input logic signed [47:0] t);
    logic signed [48:0] s;
    s = {acc[47], acc} + {t[47], t};
    if (s[48] != s[47]) begin
      return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end
    return s[47:0];
  endfunction

  logic [31:0] box_x_q, box_y_q, box_z_q, cutoff_q, sigma6_q, eps_q;
  logic        present_q, last_q;
  logic signed [34:0] dx_q, dy_q, dz_q;
  logic [63:0] rsq_q, irsq_q, s6_q, m_q, f_q;
  logic signed [47:0] acc_fx_q, acc_fy_q, acc_fz_q, acc_e_q;
  logic [8:0]  tally_q;
  logic        out_valid_q;
  logic [47:0] out_fx_q, out_fy_q, out_fz_q, out_e_q;
  logic [8:0]  out_tally_q;

  logic [33:0] ax, ay, az;
  logic        neg_e, neg_f;
  logic [63:0] e_diff, f_diff, f48;
  logic [69:0] f48_wide;
  logic [63:0] op_a, op_b, mul_res, div_quo;
  shift_e      op_sh;
  logic        mul_done, div_done;
  logic [46:0] emag, fmag;

  assign ax = mag_d(dx_q);
  assign ay = mag_d(dy_q);
  assign az = mag_d(dz_q);

  assign neg_e    = s6_q < ONE_Q32;
  assign neg_f    = s6_q < HALF_Q32;
  assign e_diff   = neg_e ? ONE_Q32 - s6_q : s6_q - ONE_Q32;
  assign f_diff   = neg_f ? HALF_Q32 - s6_q : s6_q - HALF_Q32;
  // factor 48 as 32 + 16, saturated to 64 bits
  assign f48_wide = {f_q, 5'b0} + {1'b0, f_q, 4'b0};
  assign f48      = (|f48_wide[69:64]) ? {64{1'b1}} : f48_wide[63:0];

  // energy term doubles then caps, force term caps
  assign emag = (|mul_res[63:46]) ? TERM_CAP : {mul_res[45:0], 1'b0};
  assign fmag = (|mul_res[63:47]) ? TERM_CAP : mul_res[46:0];

  always_comb begin
    unique case (cmd_i.op)
      OP_SQX: begin op_a = {32'b0, clamp_d(ax)}; op_b = op_a; op_sh = SH_0; end
      OP_SQY: begin op_a = {32'b0, clamp_d(ay)}; op_b = op_a; op_sh = SH_0; end
      OP_SQZ: begin op_a = {32'b0, clamp_d(az)}; op_b = op_a; op_sh = SH_0; end
      OP_S1:  begin op_a = {16'b0, sigma6_q, 16'b0}; op_b = irsq_q; op_sh = SH_32; end
      OP_S2,
      OP_S3:  begin op_a = s6_q; op_b = irsq_q; op_sh = SH_32; end
      OP_E1:  begin op_a = s6_q; op_b = e_diff; op_sh = SH_32; end
      OP_E2:  begin op_a = m_q;  op_b = {32'b0, eps_q}; op_sh = SH_32; end
      OP_F1:  begin op_a = s6_q; op_b = f_diff; op_sh = SH_32; end
      OP_F2:  begin op_a = f_q;  op_b = {32'b0, eps_q}; op_sh = SH_32; end
      OP_F3:  begin op_a = f_q;  op_b = irsq_q; op_sh = SH_32; end
      OP_FX:  begin op_a = f48;  op_b = {30'b0, ax}; op_sh = SH_22; end
      OP_FY:  begin op_a = f48;  op_b = {30'b0, ay}; op_sh = SH_22; end
      OP_FZ:  begin op_a = f48;  op_b = {30'b0, az}; op_sh = SH_22; end
      default: begin op_a = s6_q; op_b = irsq_q; op_sh = SH_32; end
    endcase
  end

  ljpf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .sh_i    (op_sh),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  ljpf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .den_i   (rsq_q[63:12]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q  <= BOX_RESET;
      box_y_q  <= BOX_RESET;
      box_z_q  <= BOX_RESET;
      cutoff_q <= CUTOFF_RESET;
      sigma6_q <= SIGMA6_RESET;
      eps_q    <= EPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BOX_X:   box_x_q  <= cfg_data_i;
        REG_BOX_Y:   box_y_q  <= cfg_data_i;
        REG_BOX_Z:   box_z_q  <= cfg_data_i;
        REG_CUTOFF:  cutoff_q <= cfg_data_i;
        REG_SIGMA6:  sigma6_q <= cfg_data_i;
        REG_EPSILON: eps_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= 1'b0;
      last_q      <= 1'b0;
      acc_fx_q    <= '0;
      acc_fy_q    <= '0;
      acc_fz_q    <= '0;
      acc_e_q     <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        present_q <= in_present_i;
        last_q    <= in_last_i;
      end
      if (cmd_i.commit) begin
        unique case (cmd_i.op)
          OP_E2: acc_e_q  <= sat_add(acc_e_q,  term(emag, neg_e));
          OP_FX: acc_fx_q <= sat_add(acc_fx_q, term(fmag, neg_f ^ dx_q[34]));
          OP_FY: acc_fy_q <= sat_add(acc_fy_q, term(fmag, neg_f ^ dy_q[34]));
          OP_FZ: acc_fz_q <= sat_add(acc_fz_q, term(fmag, neg_f ^ dz_q[34]));
          default: ;
        endcase
      end
      if (cmd_i.tally_inc && (tally_q < TALLY_CAP)) begin
        tally_q <= tally_q + 9'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        acc_fx_q    <= '0;
        acc_fy_q    <= '0;
        acc_fz_q    <= '0;
        acc_e_q     <= '0;
        tally_q     <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q <= $signed({3'b0, in_data_i[31:0]})    - $signed({3'b0, in_data_i[127:96]});
      dy_q <= $signed({3'b0, in_data_i[63:32]})   - $signed({3'b0, in_data_i[159:128]});
      dz_q <= $signed({3'b0, in_data_i[95:64]})   - $signed({3'b0, in_data_i[191:160]});
    end else if (cmd_i.wrap) begin
      dx_q <= wrap_d(dx_q, box_x_q);
      dy_q <= wrap_d(dy_q, box_y_q);
      dz_q <= wrap_d(dz_q, box_z_q);
    end
    if (cmd_i.wrap) begin
      rsq_q <= '0;
    end
    if (cmd_i.irsq_load) begin
      irsq_q <= div_quo;
    end
    if (cmd_i.commit) begin
      unique case (cmd_i.op)
        OP_SQX, OP_SQY, OP_SQZ: rsq_q <= rsq_q + mul_res;
        OP_S1, OP_S2, OP_S3:    s6_q  <= mul_res;
        OP_E1:                  m_q   <= mul_res;
        OP_F1, OP_F2, OP_F3:    f_q   <= mul_res;
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      out_fx_q    <= acc_fx_q;
      out_fy_q    <= acc_fy_q;
      out_fz_q    <= acc_fz_q;
      out_e_q     <= acc_e_q;
      out_tally_q <= tally_q;
    end
  end

  always_comb begin
    sts_o.pair_present = present_q;
    sts_o.last         = last_q;
    sts_o.in_range     = (rsq_q != 64'd0) && (rsq_q <= {4'b0, cutoff_q, 28'b0});
    sts_o.mul_done     = mul_done;
    sts_o.div_done     = div_done;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign force_x_o       = out_fx_q;
  assign force_y_o       = out_fy_q;
  assign force_z_o       = out_fz_q;
  assign energy_o        = out_e_q;
  assign pairs_counted_o = out_tally_q;

endmodule
`default_nettype wire

FILE: rtl/core/ljpf_ctrl.sv
// controller state machine sequencing wrap, squares, reciprocal, multiply chain and emit
`default_nettype none
module ljpf_ctrl (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  ljpf_pkg::sts_t sts_i,
  output ljpf_pkg::cmd_t cmd_o
);
  import ljpf_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  state_e close_st;

  assign close_st = sts_i.last ? ST_EMIT : ST_IDLE;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        op_d    = OP_SQX;
        state_d = sts_i.pair_present ? ST_MUL_ISSUE : close_st;
      end
      ST_MUL_ISSUE: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          if (op_q == OP_SQZ) begin
            state_d = ST_CHECK;
          end else if (op_q == OP_FZ) begin
            state_d = close_st;
          end else begin
            op_d    = op_e'(op_q + 4'd1);
            state_d = ST_MUL_ISSUE;
          end
        end
      end
      ST_CHECK: state_d = sts_i.in_range ? ST_DIV_ISSUE : close_st;
      ST_DIV_ISSUE: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          op_d    = OP_S1;
          state_d = ST_MUL_ISSUE;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.wrap      = (state_q == ST_WRAP);
    cmd_o.mul_start = (state_q == ST_MUL_ISSUE);
    cmd_o.commit    = (state_q == ST_MUL_WAIT) && sts_i.mul_done;
    cmd_o.div_start = (state_q == ST_DIV_ISSUE);
    cmd_o.irsq_load = (state_q == ST_DIV_WAIT) && sts_i.div_done;
    cmd_o.tally_inc = cmd_o.commit && (op_q == OP_FZ);
    cmd_o.emit      = (state_q == ST_EMIT) && sts_i.out_free;
    cmd_o.op        = op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SQX;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  a_mul_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_start |=> !sts_i.mul_done) else $error("multiplier finished too early");
  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> state_q == ST_MUL_WAIT) else $error("unexpected multiply result");
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == ST_DIV_WAIT) else $error("unexpected quotient");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("result overwritten");

endmodule
`default_nettype wire

FILE: rtl/core/lennard_jones_pair_force_core.sv
// lennard-jones pair force core top level: stream ports, controller and datapath
// inside cutoff: the reciprocal divider plus 14 multiplies on one shared 32x32 multiplier;
// one item in flight, next item taken once it finishes
// the result register lets a new item in while a result waits on the master side
// reset (async, active low) clears accumulators, tally and handshake, loads default registers
`default_nettype none
module lennard_jones_pair_force_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [31:0]  cfg_data_i,
  // pair requests
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // atom_x, atom_y, atom_z, neighbour_x, neighbour_y, neighbour_z
  input  wire logic [191:0] s_axis_tdata,
  // pair_present
  input  wire logic         s_axis_tuser,
  // last_neighbour
  input  wire logic         s_axis_tlast,
  // per-atom results
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // force_x, force_y, force_z, energy, pairs_counted, zero pad
  output logic [207:0]      m_axis_tdata
);
  import ljpf_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [47:0] force_x, force_y, force_z, energy;
  logic [8:0]  pairs_counted;

  // sequencer: one state per step, multiply steps share issue and wait states
  ljpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, accumulators and the output register
  ljpf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .in_data_i       (s_axis_tdata),
    .in_present_i    (s_axis_tuser),
    .in_last_i       (s_axis_tlast),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .force_x_o       (force_x),
    .force_y_o       (force_y),
    .force_z_o       (force_z),
    .energy_o        (energy),
    .pairs_counted_o (pairs_counted)
  );

  // pack results, lowest field first
  assign m_axis_tdata = {7'b0, pairs_counted, energy, force_z, force_y, force_x};

endmodule
`default_nettype wire
